// ----- rtl/core/hmmev_pkg.sv -----
package hmmev_pkg;

  localparam int unsigned LogW    = 40;
  localparam int unsigned ProbW   = 16;
  localparam int unsigned ProdW   = 32;
  localparam int unsigned XW      = 24;
  localparam int unsigned SumW    = 48;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QIdxW   = 2;

  localparam logic [3:0]  RegLogLik  = 4'd0;

  localparam logic signed [55:0] Log2eQ30 = 56'sd1549082005;
  localparam logic [29:0]        Ln2Q30   = 30'd744261118;
  localparam logic signed [41:0] XClampHi = 42'sd4194304;
  localparam logic signed [41:0] XClampLo = -42'sd4194304;
  localparam logic [17:0]        Recip6   = 18'd174763;
  localparam logic [SumW-1:0]    Max48    = {SumW{1'b1}};

  typedef struct packed {
    logic [ProdW-1:0]     prod;
    logic signed [XW-1:0] x;
    logic                 zero;
    logic                 last;
  } term_t;

  typedef enum logic [3:0] {
    StIdle,
    StY,
    StT,
    StSq,
    StCube,
    StPoly,
    StMant,
    StScale,
    StShift,
    StAcc
  } back_state_e;

  function automatic logic [30:0] pow2_frac(input logic [3:0] k);
    logic [30:0] r;
    begin
      case (k)
        4'd0: r = 31'd1073741824;
        4'd1: r = 31'd1121280436;
        4'd2: r = 31'd1170923762;
        4'd3: r = 31'd1222764986;
        4'd4: r = 31'd1276901417;
        4'd5: r = 31'd1333434672;
        4'd6: r = 31'd1392470869;
        4'd7: r = 31'd1454120821;
        4'd8: r = 31'd1518500250;
        4'd9: r = 31'd1585730000;
        4'd10: r = 31'd1655936265;
        4'd11: r = 31'd1729250834;
        4'd12: r = 31'd1805811301;
        4'd13: r = 31'd1885761398;
        4'd14: r = 31'd1969251188;
        default: r = 31'd2056437386;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- rtl/core/hmmev_front.sv -----
module hmmev_front (
  input  logic [hmmev_pkg::ProbW-1:0]       joint_prob_i,
  input  logic [hmmev_pkg::ProbW-1:0]       emit_prob_i,
  input  logic signed [hmmev_pkg::LogW-1:0] fwd_log_i,
  input  logic signed [hmmev_pkg::LogW-1:0] bwd_log_i,
  input  logic                              last_term_i,
  input  logic signed [hmmev_pkg::LogW-1:0] log_lik_i,
  output hmmev_pkg::term_t                  term_o
);

  logic [31:0]        prod;
  logic signed [41:0] xsum;

  // joint weight times emission, and the clamped exponent
  assign prod = 32'(joint_prob_i) * 32'(emit_prob_i);
  assign xsum = 42'(fwd_log_i) + 42'(bwd_log_i) - 42'(log_lik_i);

  always_comb begin
    term_o.prod = prod[hmmev_pkg::ProdW-1:0];
    term_o.zero = (prod == 32'd0);
    term_o.last = last_term_i;
    if (xsum > hmmev_pkg::XClampHi) begin
      term_o.x = hmmev_pkg::XClampHi[hmmev_pkg::XW-1:0];
    end else if (xsum < hmmev_pkg::XClampLo) begin
      term_o.x = hmmev_pkg::XClampLo[hmmev_pkg::XW-1:0];
    end else begin
      term_o.x = xsum[hmmev_pkg::XW-1:0];
    end
  end

endmodule

// ----- rtl/core/hmmev_queue.sv -----
module hmmev_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  hmmev_pkg::term_t wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             empty_o,
  output hmmev_pkg::term_t rdata_o
);

  hmmev_pkg::term_t             mem_q [hmmev_pkg::QDepth];
  logic [hmmev_pkg::QIdxW-1:0]  wptr_q, rptr_q;
  logic [hmmev_pkg::QIdxW:0]    cnt_q;

  assign full_o  = (cnt_q == (hmmev_pkg::QIdxW+1)'(hmmev_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i && !full_o) wptr_q <= wptr_q + 1'b1;
      if (rd_i && !empty_o) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (hmmev_pkg::QIdxW+1)'(wr_i && !full_o)
                     - (hmmev_pkg::QIdxW+1)'(rd_i && !empty_o);
    end
  end

endmodule

// ----- rtl/core/hmmev_back.sv -----
module hmmev_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  hmmev_pkg::term_t            q_data_i,
  output logic                        q_rd_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [hmmev_pkg::SumW-1:0]  mean_value_o,
  output logic                        saturated_o
);

  hmmev_pkg::back_state_e state_q, state_d;

  hmmev_pkg::term_t   cur_q;
  logic signed [23:0] y_q;
  logic signed [7:0]  n_q;
  logic [3:0]         k_q;
  logic [25:0]        t_q;
  logic [21:0]        t2_q;
  logic [20:0]        th_q;
  logic [17:0]        c_q;
  logic [31:0]        p_q;
  logic [31:0]        m_q;
  logic [62:0]        v_q;
  logic [47:0]        term_q;
  logic               tovf_q;

  logic [47:0] sum_q;
  logic        flag_q;
  logic        res_vld_q;
  logic [47:0] res_sum_q;
  logic        res_flag_q;

  logic signed [55:0] ym;
  logic [41:0]        tm;
  logic [51:0]        tt;
  logic [47:0]        cube;
  logic [35:0]        qm;
  logic [61:0]        mm;
  logic [6:0]         sh;
  logic [62:0]        rsh;
  logic [62:0]        chk;
  logic [62:0]        lsh;
  logic [47:0]        term_d;
  logic               tovf_d;
  logic [48:0]        acc;
  logic               stall_out;

  assign ym   = 56'(cur_q.x) * hmmev_pkg::Log2eQ30;
  assign tm   = 42'(y_q[11:0]) * 42'(hmmev_pkg::Ln2Q30);
  assign tt   = 52'(t_q) * 52'(t_q);
  assign cube = 48'(t2_q) * 48'(t_q);
  assign qm   = 36'(c_q) * 36'(hmmev_pkg::Recip6);
  assign mm   = 62'(hmmev_pkg::pow2_frac(k_q)) * 62'(p_q);

  // scale by 2^(n-28): right shift truncates, either shift saturates on overflow
  always_comb begin
    sh     = 7'd0;
    rsh    = '0;
    chk    = '0;
    lsh    = '0;
    term_d = '0;
    tovf_d = 1'b0;
    if (n_q <= 8'sd28) begin
      sh     = 7'(8'sd28 - n_q);
      rsh    = v_q >> sh;
      tovf_d = |rsh[62:48];
      term_d = tovf_d ? hmmev_pkg::Max48 : rsh[47:0];
    end else begin
      sh = 7'(n_q - 8'sd28);
      if (sh >= 7'd48) begin
        tovf_d = 1'b1;
      end else begin
        chk    = v_q >> (7'd48 - sh);
        lsh    = v_q << sh;
        tovf_d = (chk != '0);
      end
      term_d = tovf_d ? hmmev_pkg::Max48 : lsh[47:0];
    end
    if (cur_q.zero) begin
      term_d = '0;
      tovf_d = 1'b0;
    end
  end

  assign acc       = {1'b0, sum_q} + {1'b0, term_q};
  assign stall_out = cur_q.last && res_vld_q && !pop_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      hmmev_pkg::StIdle:  if (!q_empty_i) state_d = hmmev_pkg::StY;
      hmmev_pkg::StY:     state_d = hmmev_pkg::StT;
      hmmev_pkg::StT:     state_d = hmmev_pkg::StSq;
      hmmev_pkg::StSq:    state_d = hmmev_pkg::StCube;
      hmmev_pkg::StCube:  state_d = hmmev_pkg::StPoly;
      hmmev_pkg::StPoly:  state_d = hmmev_pkg::StMant;
      hmmev_pkg::StMant:  state_d = hmmev_pkg::StScale;
      hmmev_pkg::StScale: state_d = hmmev_pkg::StShift;
      hmmev_pkg::StShift: state_d = hmmev_pkg::StAcc;
      hmmev_pkg::StAcc:   if (!stall_out) state_d = hmmev_pkg::StIdle;
      default:            state_d = hmmev_pkg::StIdle;
    endcase
  end

  always_comb begin
    q_rd_o       = (state_q == hmmev_pkg::StIdle) && !q_empty_i;
    empty_o      = !res_vld_q;
    mean_value_o = res_sum_q;
    saturated_o  = res_flag_q;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      hmmev_pkg::StIdle:  cur_q <= q_data_i;
      hmmev_pkg::StY:     y_q <= ym[53:30];
      hmmev_pkg::StT: begin
        n_q <= y_q[23:16];
        k_q <= y_q[15:12];
        t_q <= tm[41:16];
      end
      hmmev_pkg::StSq: begin
        t2_q <= tt[51:30];
        th_q <= tt[51:31];
      end
      hmmev_pkg::StCube:  c_q <= cube[47:30];
      hmmev_pkg::StPoly:  p_q <= 32'h4000_0000 + 32'(t_q) + 32'(th_q) + 32'(qm[35:20]);
      hmmev_pkg::StMant:  m_q <= mm[61:30];
      hmmev_pkg::StScale: v_q <= 63'(cur_q.prod) * 63'(m_q);
      hmmev_pkg::StShift: begin
        term_q <= term_d;
        tovf_q <= tovf_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= hmmev_pkg::StIdle;
      sum_q      <= '0;
      flag_q     <= 1'b0;
      res_vld_q  <= 1'b0;
      res_sum_q  <= '0;
      res_flag_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // a new result may replace the one popped in the same cycle
      if (state_q == hmmev_pkg::StAcc && !stall_out && cur_q.last) begin
        res_vld_q <= 1'b1;
      end else if (pop_i && res_vld_q) begin
        res_vld_q <= 1'b0;
      end
      if (state_q == hmmev_pkg::StAcc && !stall_out) begin
        if (cur_q.last) begin
          res_sum_q  <= acc[48] ? hmmev_pkg::Max48 : acc[47:0];
          res_flag_q <= flag_q | tovf_q | acc[48];
          sum_q      <= '0;
          flag_q     <= 1'b0;
        end else begin
          sum_q  <= acc[48] ? hmmev_pkg::Max48 : acc[47:0];
          flag_q <= flag_q | tovf_q | acc[48];
        end
      end
    end
  end

endmodule

// ----- rtl/core/hmm_expected_value_accumulator.sv -----
// channel   direction  handshake             payload
// input     in         push / full           joint_prob, emit_prob, fwd_log, bwd_log, last_term
// result    out        empty / pop           mean_value, saturated
// config    in         apb psel/penable      log_likelihood at byte address 0 (64-bit data)
//
// the back end works on one term at a time: one idle/load step and nine steps
// of the exponential sequencer, each at most one multiplier deep
// up to four classified terms wait in the queue between front and back
// reset clears the sum, the flag, the queue and log_likelihood
// a finished result waits in its register; the sequencer only stalls when a
// second result is ready before the first one is popped
module hmm_expected_value_accumulator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input transfer
  input  logic                              push,
  output logic                              full,
  input  logic [hmmev_pkg::ProbW-1:0]       joint_prob_i,
  input  logic [hmmev_pkg::ProbW-1:0]       emit_prob_i,
  input  logic signed [hmmev_pkg::LogW-1:0] fwd_log_i,
  input  logic signed [hmmev_pkg::LogW-1:0] bwd_log_i,
  input  logic                              last_term_i,
  // result transfer
  output logic                              empty,
  input  logic                              pop,
  output logic [hmmev_pkg::SumW-1:0]        mean_value_o,
  output logic                              saturated_o,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [63:0]                       pwdata,
  output logic [63:0]                       prdata,
  output logic                              pready
);

  logic signed [hmmev_pkg::LogW-1:0] log_lik_q;
  hmmev_pkg::term_t                  fterm, qterm;
  logic                              q_empty, q_rd;
  logic                              reg_hit;

  // register index sits in paddr[3]
  assign reg_hit = ({3'b000, paddr[3]} == hmmev_pkg::RegLogLik);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? 64'(log_lik_q) : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_lik_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      log_lik_q <= pwdata[hmmev_pkg::LogW-1:0];
    end
  end

  // front: product and clamped exponent argument
  hmmev_front u_front (
    .joint_prob_i (joint_prob_i),
    .emit_prob_i  (emit_prob_i),
    .fwd_log_i    (fwd_log_i),
    .bwd_log_i    (bwd_log_i),
    .last_term_i  (last_term_i),
    .log_lik_i    (log_lik_q),
    .term_o       (fterm)
  );

  // decoupling queue
  hmmev_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (fterm),
    .full_o  (full),
    .rd_i    (q_rd),
    .empty_o (q_empty),
    .rdata_o (qterm)
  );

  // back: exponential, scaling, saturating accumulation, result register
  hmmev_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (qterm),
    .q_rd_o       (q_rd),
    .empty_o      (empty),
    .pop_i        (pop),
    .mean_value_o (mean_value_o),
    .saturated_o  (saturated_o)
  );

endmodule

// ----- verif/tb_hmm_expected_value_accumulator.sv -----
`timescale 1ns / 100ps

module tb_hmm_expected_value_accumulator;

  localparam int unsigned CycleLimit = 400000;
  // settle time covers the back end and up to four terms still in the queue
  localparam int unsigned SettleCycles = 80;
  localparam logic [63:0] Sum48Max = 64'hFFFF_FFFF_FFFF;
  localparam longint Log2eScaled = 64'sd1549082005;
  localparam logic [63:0] Ln2Scaled = 64'd744261118;
  localparam longint ExpClamp = 64'sd4194304;
  localparam longint LogMin = -64'sd549755813888;

  localparam logic [63:0] FracPow2 [16] = '{
    64'd1073741824, 64'd1121280436, 64'd1170923762, 64'd1222764986,
    64'd1276901417, 64'd1333434672, 64'd1392470869, 64'd1454120821,
    64'd1518500250, 64'd1585730000, 64'd1655936265, 64'd1729250834,
    64'd1805811301, 64'd1885761398, 64'd1969251188, 64'd2056437386
  };

  typedef struct {
    logic [hmmev_pkg::SumW-1:0] mean;
    logic                       sat;
  } sum_result_t;

  // clock, reset and dut ports
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [hmmev_pkg::ProbW-1:0] joint_prob = '0;
  logic [hmmev_pkg::ProbW-1:0] emit_prob = '0;
  logic signed [hmmev_pkg::LogW-1:0] fwd_log = '0;
  logic signed [hmmev_pkg::LogW-1:0] bwd_log = '0;
  logic last_term = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [hmmev_pkg::SumW-1:0] mean_value;
  logic saturated;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  // predictor state: its own copy of the register, sum and flag
  logic signed [hmmev_pkg::LogW-1:0] loglik_q = '0;
  logic [63:0] acc_sum = '0;
  logic acc_sat = 1'b0;
  sum_result_t pending_sums[$];

  // traffic shaping knobs
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned terms_sent = 0;
  int unsigned sums_seen = 0;
  int unsigned sat_seen = 0;
  int unsigned full_seen = 0;

  always #2 clk = ~clk;

  hmm_expected_value_accumulator dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push         (push),
    .full         (full),
    .joint_prob_i (joint_prob),
    .emit_prob_i  (emit_prob),
    .fwd_log_i    (fwd_log),
    .bwd_log_i    (bwd_log),
    .last_term_i  (last_term),
    .empty        (empty),
    .pop          (pop),
    .mean_value_o (mean_value),
    .saturated_o  (saturated),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // one term of the expected count in Q16.32, flag on overflow
  function automatic logic [63:0] weighted_term(input logic [63:0] prod, input longint x_in,
                                                output logic ovf);
    longint x, y, n, sh;
    logic [63:0] f, t, t2, p, m, v;
    begin
      ovf = 1'b0;
      if (prod == 0) return 64'd0;
      x = x_in;
      if (x > ExpClamp) x = ExpClamp;
      if (x < -ExpClamp) x = -ExpClamp;
      // base-2 exponent, floor semantics through arithmetic shift
      y = (x * Log2eScaled) >>> 30;
      n = y >>> 16;
      f = 64'(y - n * 65536);
      t = ((f & 64'hFFF) * Ln2Scaled) >> 16;
      t2 = (t * t) >> 30;
      p = (64'd1 << 30) + t + ((t * t) >> 31) + ((t2 * t) >> 30) / 6;
      m = (FracPow2[f[15:12]] * p) >> 30;
      v = prod * m;
      sh = 28 - n;
      if (sh > 0) begin
        if (sh >= 64) return 64'd0;
        v = v >> sh;
      end else begin
        if (-sh >= 48 || v > (Sum48Max >> (-sh))) begin
          ovf = 1'b1;
          return Sum48Max;
        end
        v = v << (-sh);
      end
      if (v > Sum48Max) begin
        ovf = 1'b1;
        return Sum48Max;
      end
      return v;
    end
  endfunction

  // fold an accepted term into the predicted sum
  task automatic accumulate_term();
    logic [63:0] prod, term;
    logic ovf;
    longint x;
    sum_result_t r;
    begin
      prod = 64'(joint_prob) * 64'(emit_prob);
      x = longint'(fwd_log) + longint'(bwd_log) - longint'(loglik_q);
      term = weighted_term(prod, x, ovf);
      if (ovf) acc_sat = 1'b1;
      acc_sum = acc_sum + term;
      if (acc_sum > Sum48Max) begin
        acc_sum = Sum48Max;
        acc_sat = 1'b1;
      end
      if (last_term) begin
        r.mean = acc_sum[hmmev_pkg::SumW-1:0];
        r.sat = acc_sat;
        pending_sums.push_back(r);
        acc_sum = '0;
        acc_sat = 1'b0;
      end
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    begin
      errors++;
      $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
    end
  endtask

  // send one term; gaps by the current idle rate
  task automatic send_term(input logic [hmmev_pkg::ProbW-1:0] jp,
                           input logic [hmmev_pkg::ProbW-1:0] ep,
                           input logic signed [hmmev_pkg::LogW-1:0] fl,
                           input logic signed [hmmev_pkg::LogW-1:0] bl,
                           input logic lt);
    begin
      while ($urandom_range(99) < send_idle_pct) begin
        @(negedge clk);
        push <= 1'b0;
      end
      @(negedge clk);
      push <= 1'b1;
      joint_prob <= jp;
      emit_prob <= ep;
      fwd_log <= fl;
      bwd_log <= bl;
      last_term <= lt;
      @(posedge clk);
      while (full) begin
        full_seen++;
        @(posedge clk);
      end
      accumulate_term();
      terms_sent++;
    end
  endtask

  task automatic stop_sending();
    begin
      @(negedge clk);
      push <= 1'b0;
    end
  endtask

  // wait for every predicted sum, then let trailing terms clear the back end
  task automatic wait_drained();
    begin
      stop_sending();
      while (pending_sums.size() != 0) @(posedge clk);
      repeat (SettleCycles) @(posedge clk);
    end
  endtask

  // apb write of the log likelihood; only called with the block idle
  task automatic write_loglik(input logic signed [hmmev_pkg::LogW-1:0] val);
    begin
      @(negedge clk);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= 4'(hmmev_pkg::RegLogLik << 3);
      pwdata <= 64'(val);
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      loglik_q = val;
      @(negedge clk);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // split a wanted exponent into legal forward and backward logs
  task automatic well_formed_term(input logic lt);
    longint x, s, fl;
    logic [hmmev_pkg::ProbW-1:0] jp, ep;
    begin
      // exponent mostly near zero, sometimes far out on either side
      case ($urandom_range(9))
        0:       x = -longint'($urandom_range(64'd40 << 16));
        1:       x = longint'($urandom_range(64'd14 << 16));
        default: x = longint'($urandom_range(64'd8 << 16)) - (64'sd6 << 16);
      endcase
      s = x + longint'(loglik_q);
      if (s > 0) s = 0;
      if (s < 2 * LogMin) s = 2 * LogMin;
      fl = -longint'(rand64() % 64'(-s + 1));
      if (fl < LogMin) fl = LogMin;
      if (s - fl < LogMin) fl = s - LogMin;
      jp = ($urandom_range(9) == 0) ? hmmev_pkg::ProbW'(0)
                                    : hmmev_pkg::ProbW'($urandom_range(32768));
      ep = hmmev_pkg::ProbW'($urandom_range(32768));
      send_term(jp, ep, hmmev_pkg::LogW'(fl), hmmev_pkg::LogW'(s - fl), lt);
    end
  endtask

  // random sequences, with some raw noise mixed in
  task automatic random_sequences(input int unsigned n_terms);
    int unsigned sent, len;
    begin
      sent = 0;
      while (sent < n_terms) begin
        if ($urandom_range(99) < 15) begin
          send_term(hmmev_pkg::ProbW'($urandom), hmmev_pkg::ProbW'($urandom),
                    hmmev_pkg::LogW'(rand64()), hmmev_pkg::LogW'(rand64()),
                    1'($urandom));
          sent++;
        end else begin
          len = $urandom_range(1, 6);
          for (int unsigned i = 0; i < len; i++) well_formed_term(i == len - 1);
          sent += len;
        end
      end
      // close any open sequence
      well_formed_term(1'b1);
    end
  endtask

  task automatic test_directed();
    logic signed [hmmev_pkg::LogW-1:0] pos_max, neg_max;
    begin
      pos_max = {1'b0, {(hmmev_pkg::LogW-1){1'b1}}};
      neg_max = {1'b1, {(hmmev_pkg::LogW-1){1'b0}}};
      // unit weight, zero exponent
      send_term(16'd32768, 16'd32768, '0, '0, 1'b1);
      // zero product with huge exponent: no flag
      send_term(16'd0, 16'hFFFF, pos_max, pos_max, 1'b1);
      send_term(16'hFFFF, 16'd0, pos_max, pos_max, 1'b1);
      // huge exponent saturates the term
      send_term(16'd1, 16'd1, pos_max, pos_max, 1'b1);
      // tiny exponent gives zero
      send_term(16'hFFFF, 16'hFFFF, neg_max, neg_max, 1'b1);
      // probabilities above one used unclamped
      send_term(16'hFFFF, 16'hFFFF, '0, '0, 1'b1);
      send_term(16'hFFFF, 16'h8000, -40'sd65536, '0, 1'b1);
      // sum overflow from terms that each fit
      for (int i = 0; i < 3; i++) send_term(16'd32768, 16'd32768, 40'sd681391, '0, i == 2);
      // flag clears after the sum is emitted
      send_term(16'd16384, 16'd16384, -40'sd131072, -40'sd65536, 1'b1);
      // multi-term sequence, exponent fractions across the table
      for (int i = 0; i < 16; i++)
        send_term(16'd32768, 16'd20000, -hmmev_pkg::LogW'(i * 4096 + 123), '0, i == 15);
      wait_drained();
    end
  endtask

  task automatic test_loglik_extremes();
    begin
      write_loglik({1'b1, {(hmmev_pkg::LogW-1){1'b0}}});
      send_term(16'd32768, 16'd32768, '0, '0, 1'b1);
      send_term(16'd100, 16'd200, {1'b1, {(hmmev_pkg::LogW-1){1'b0}}}, '0, 1'b1);
      random_sequences(40);
      wait_drained();
      write_loglik('0);
      random_sequences(40);
      wait_drained();
    end
  endtask

  task automatic test_idle_phase(input int unsigned s_pct, input int unsigned r_pct);
    begin
      send_idle_pct = s_pct;
      recv_stall_pct = r_pct;
      write_loglik(-hmmev_pkg::LogW'($urandom_range(64'd200 << 16)));
      random_sequences(150);
      wait_drained();
      write_loglik(-hmmev_pkg::LogW'(rand64() % 64'd549755813889));
      random_sequences(150);
      wait_drained();
    end
  endtask

  // receiver holds off while short sequences pile up behind the result
  task automatic test_backpressure();
    begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = 600;
      for (int i = 0; i < 40; i++) well_formed_term(1'($urandom_range(1)));
      well_formed_term(1'b1);
      // sender pauses until every sum is out
      stop_sending();
      while (pending_sums.size() != 0) @(posedge clk);
      random_sequences(30);
      wait_drained();
    end
  endtask

  // result checking
  always @(posedge clk) begin
    sum_result_t want;
    if (rst_n && pop && !empty) begin
      sums_seen++;
      if (saturated) sat_seen++;
      if (pending_sums.size() == 0) begin
        report("unexpected sum", 64'(mean_value), '0);
      end else begin
        want = pending_sums.pop_front();
        if (mean_value !== want.mean) report("mean_value", 64'(mean_value), 64'(want.mean));
        if (saturated !== want.sat) report("saturated", 64'(saturated), 64'(want.sat));
      end
    end
  end

  // pop pacing, with a long hold-off when asked
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("hmm_expected_value_accumulator regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_loglik_extremes();
    test_idle_phase(0, 0);
    test_idle_phase(55, 0);
    test_idle_phase(0, 55);
    test_idle_phase(30, 30);
    test_backpressure();
    $display("covered %0d terms and %0d sums (%0d saturated) over several log likelihoods,",
             terms_sent, sums_seen, sat_seen);
    $display("idle and stall mixes, and %0d cycles of input held back by a full block",
             full_seen);
    if (errors == 0) begin
      $display("hmm_expected_value_accumulator regression: pass");
    end else begin
      $display("hmm_expected_value_accumulator regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/hmmev_pkg.sv
rtl/core/hmmev_front.sv
rtl/core/hmmev_queue.sv
rtl/core/hmmev_back.sv
rtl/core/hmm_expected_value_accumulator.sv
verif/tb_hmm_expected_value_accumulator.sv
